@@ sv/mau_pkg.sv @@
// Package for the modular arithmetic unit: operation codes and shared types.
package mau_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4
  } op_t;

  localparam int OpWidth = 3;
  localparam int OperandWidth = 64;

endpackage

@@ sv/modular_arithmetic_unit.sv @@
// Modular arithmetic unit: one item at a time, all reductions through a shared serial reducer.
// Each transaction is reduced by one shared shift-and-subtract unit: both operands in turn,
// then each product for multiply, power and divide, which step through the exponent bit by
// bit, up to 64 exponent bits for power and up to 31 (m-2) for divide. in_tready is high only
// while the block is idle; a finished residue waits in the output register while the next
// transaction runs. cfg_ready also needs that register empty and no input transaction offered.
module modular_arithmetic_unit #(
  parameter int RESIDUE_WIDTH = 31
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [135:0]             in_tdata,   // op[2:0], lhs[66:3], rhs[130:67], zero pad
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [((RESIDUE_WIDTH+7)/8)*8-1:0] out_tdata, // residue, zero pad
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [RESIDUE_WIDTH-1:0] cfg_data
);
  import mau_pkg::*;

  localparam int W = RESIDUE_WIDTH;
  localparam int OutW = ((RESIDUE_WIDTH + 7) / 8) * 8;
  localparam logic [W-1:0] ModReset = W'(64'd1000000007);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RED_A = 9'b000000010,
    S_RED_B = 9'b000000100,
    S_ARITH = 9'b000001000,
    S_PSTEP = 9'b000010000,
    S_PMUL  = 9'b000100000,
    S_PSQR  = 9'b001000000,
    S_FMUL  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [W-1:0] mod_r;
  logic [2:0]   op_r, op_nxt;
  logic [OperandWidth-1:0] lhs_r, lhs_nxt, rhs_r, rhs_nxt, exp_r, exp_nxt;
  logic [W-1:0] a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt, base_r, base_nxt;
  logic [W-1:0] res_r, res_nxt;
  logic [W-1:0] obuf_r, obuf_nxt;
  logic         ovld_r, ovld_nxt;
  logic         issued_r, issued_nxt;
  logic         fin_r, fin_nxt;
  logic [OperandWidth-1:0] prod_r, prod_nxt;
  logic [OperandWidth-1:0] red_val;
  logic         red_start;
  logic         red_done;
  logic [W-1:0] red_rem;
  logic [W:0]   sum, dif;
  logic         mod_ok;

  assign mod_ok = mod_r >= W'(2);

  mau_modred #(.W(W)) u_red (
    .clk(clk), .rst_n(rst_n), .start(red_start), .value(red_val), .m(mod_r),
    .done(red_done), .rem(red_rem)
  );

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !ovld_r && !in_tvalid;
  assign out_tvalid = ovld_r;
  assign out_tdata  = OutW'(obuf_r);

  assign sum = {1'b0, a_r} + {1'b0, b_r};
  assign dif = {1'b0, a_r} - {1'b0, b_r};

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    lhs_nxt    = lhs_r;
    rhs_nxt    = rhs_r;
    exp_nxt    = exp_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    acc_nxt    = acc_r;
    base_nxt   = base_r;
    res_nxt    = res_r;
    obuf_nxt   = obuf_r;
    ovld_nxt   = ovld_r;
    issued_nxt = issued_r;
    fin_nxt    = fin_r;
    prod_nxt   = prod_r;
    red_start  = 1'b0;
    red_val    = lhs_r;
    if (out_tvalid && out_tready) ovld_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          op_nxt  = in_tdata[2:0];
          lhs_nxt = in_tdata[66:3];
          rhs_nxt = in_tdata[130:67];
          issued_nxt = 1'b0;
          state_nxt = S_RED_A;
        end
      end
      S_RED_A: begin
        red_val = lhs_r;
        if (!mod_ok) begin
          res_nxt = '0;
          state_nxt = S_OUT;
        end else if (!issued_r) begin
          red_start = 1'b1;
          issued_nxt = 1'b1;
        end else if (red_done) begin
          a_nxt = red_rem;
          issued_nxt = 1'b0;
          state_nxt = S_RED_B;
        end
      end
      S_RED_B: begin
        red_val = rhs_r;
        if (!issued_r) begin
          red_start = 1'b1;
          issued_nxt = 1'b1;
        end else if (red_done) begin
          b_nxt = red_rem;
          issued_nxt = 1'b0;
          state_nxt = S_ARITH;
        end
      end
      S_ARITH: begin
        acc_nxt = W'(1);
        fin_nxt = 1'b0;
        unique case (op_r)
          OP_ADD: begin
            res_nxt = (sum >= {1'b0, mod_r}) ? W'(sum - {1'b0, mod_r}) : sum[W-1:0];
            state_nxt = S_OUT;
          end
          OP_SUB: begin
            res_nxt = (a_r >= b_r) ? dif[W-1:0] : W'(dif + {1'b0, mod_r});
            state_nxt = S_OUT;
          end
          OP_MUL: begin
            base_nxt = b_r;
            acc_nxt  = a_r;
            state_nxt = S_FMUL;
          end
          OP_DIV: begin
            base_nxt = b_r;
            exp_nxt  = OperandWidth'(mod_r) - OperandWidth'(2);
            state_nxt = S_PSTEP;
          end
          OP_POW: begin
            base_nxt = a_r;
            exp_nxt  = rhs_r;
            state_nxt = S_PSTEP;
          end
          default: begin
            res_nxt = '0;
            state_nxt = S_OUT;
          end
        endcase
        if (op_r == OP_DIV || op_r == OP_POW)
          acc_nxt = (mod_r == W'(1)) ? '0 : W'(1);
      end
      S_PSTEP: begin
        if (exp_r == '0) begin
          if (op_r == OP_DIV) begin
            base_nxt = acc_r;
            acc_nxt  = a_r;
            state_nxt = S_FMUL;
          end else begin
            res_nxt = acc_r;
            state_nxt = S_OUT;
          end
        end else if (exp_r[0]) begin
          state_nxt = S_PMUL;
        end else begin
          state_nxt = S_PSQR;
        end
      end
      S_PMUL: begin
        red_val = prod_r;
        if (!issued_r) begin
          prod_nxt = OperandWidth'(acc_r) * OperandWidth'(base_r);
          fin_nxt = 1'b1;
          issued_nxt = 1'b1;
        end else if (fin_r) begin
          red_start = 1'b1;
          fin_nxt = 1'b0;
        end else if (red_done) begin
          acc_nxt = red_rem;
          issued_nxt = 1'b0;
          state_nxt = S_PSQR;
        end
      end
      S_PSQR: begin
        red_val = prod_r;
        if (!issued_r) begin
          prod_nxt = OperandWidth'(base_r) * OperandWidth'(base_r);
          fin_nxt = 1'b1;
          issued_nxt = 1'b1;
        end else if (fin_r) begin
          red_start = 1'b1;
          fin_nxt = 1'b0;
        end else if (red_done) begin
          base_nxt = red_rem;
          exp_nxt = exp_r >> 1;
          issued_nxt = 1'b0;
          state_nxt = S_PSTEP;
        end
      end
      S_FMUL: begin
        red_val = prod_r;
        if (!issued_r) begin
          prod_nxt = OperandWidth'(acc_r) * OperandWidth'(base_r);
          fin_nxt = 1'b1;
          issued_nxt = 1'b1;
        end else if (fin_r) begin
          red_start = 1'b1;
          fin_nxt = 1'b0;
        end else if (red_done) begin
          res_nxt = red_rem;
          issued_nxt = 1'b0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovld_r || out_tready) begin
          obuf_nxt = res_r;
          ovld_nxt = 1'b1;
          issued_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    lhs_r    <= lhs_nxt;
    rhs_r    <= rhs_nxt;
    exp_r    <= exp_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    acc_r    <= acc_nxt;
    base_r   <= base_nxt;
    res_r    <= res_nxt;
    obuf_r   <= obuf_nxt;
    prod_r   <= prod_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovld_r   <= 1'b0;
      issued_r <= 1'b0;
      fin_r    <= 1'b0;
      mod_r    <= ModReset;
    end else begin
      state_r  <= state_nxt;
      ovld_r   <= ovld_nxt;
      issued_r <= issued_nxt;
      fin_r    <= fin_nxt;
      if (cfg_valid && cfg_ready) mod_r <= cfg_data;
    end
  end
endmodule

@@ sv/mau_modred.sv @@
// Bit-serial modular reducer: reduces a 64-bit value modulo m, one bit per cycle.
module mau_modred #(
  parameter int W = 31
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [mau_pkg::OperandWidth-1:0]  value,
  input  logic [W-1:0]                      m,
  output logic                              done,
  output logic [W-1:0]                      rem
);
  import mau_pkg::*;

  localparam int CntW = $clog2(OperandWidth + 1);

  logic [OperandWidth-1:0] val_r, val_nxt;
  logic [W-1:0]            rem_r, rem_nxt;
  logic [CntW-1:0]         cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [W:0]              shifted;
  logic [W:0]              diff;

  assign shifted = {rem_r, val_r[OperandWidth-1]};
  assign diff    = shifted - {1'b0, m};

  always_comb begin
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      val_nxt  = value;
      rem_nxt  = '0;
      cnt_nxt  = CntW'(OperandWidth);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt = {val_r[OperandWidth-2:0], 1'b0};
      rem_nxt = (shifted >= {1'b0, m}) ? diff[W-1:0] : shifted[W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule
